/* src/serial_slot_sort_and_tail_emit_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the serial slot sort and tail emit unit.
// Each macro expects a clock named clk and a reset named rst in scope.
// ----------------------------------------------------------------------------
`ifndef SERIAL_SLOT_SORT_AND_TAIL_EMIT_UNIT_DEFINES_SVH
`define SERIAL_SLOT_SORT_AND_TAIL_EMIT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sste assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sste assertion failed");

`endif

/* src/sste_pkg.sv */
// ----------------------------------------------------------------------------
// sste_pkg
// Shared constants, codes and command/status types of the sort and emit unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sste_pkg;

  localparam int DEPTH     = 64;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SER_W     = 32;
  localparam int TAG_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [SER_W-1:0] ser;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENTRY         = 3'd0,
    ST_NONE_LOADED   = 3'd1,
    ST_TOO_MANY      = 3'd2,
    ST_OUT_OF_BOUNDS = 3'd3,
    ST_DUPLICATE     = 3'd4,
    ST_NONE_EMITTED  = 3'd5,
    ST_CAPACITY      = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEWEST = 1'b0,
    REG_HELD   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_MAX,
    SEL_CUR,
    SEL_FROM
  } ser_sel_t;

  typedef struct packed {
    logic     calc_lo;
    logic     pos_clr;
    logic     pos_inc;
    logic     latch_cur;
    logic     rd_tgt;
    logic     wr_tgt;
    logic     wr_pos;
    logic     emit_start;
    logic     rd_emit;
    logic     load_entry;
    logic     report;
    status_t  rep_code;
    ser_sel_t ser_sel;
    logic     clear_load;
  } sste_cmd_t;

  typedef struct packed {
    logic overflowed;
    logic count_zero;
    logic too_many;
    logic oob;
    logic at_home;
    logic dup;
    logic last_pos;
    logic none_emit;
    logic last_emit;
    logic out_free;
  } sste_stat_t;

endpackage

/* src/sste_ram.sv */
// ----------------------------------------------------------------------------
// sste_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sste_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/sste_ctrl.sv */
// ----------------------------------------------------------------------------
// sste_ctrl
// Sequencer for load, in-place placement sort and ordered emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sste_ctrl
  import sste_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       final_item,
  output logic       in_ready,
  input  sste_stat_t stat,
  output sste_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_RDPOS,
    S_LATCH,
    S_CHECK,
    S_TGT,
    S_SWAP,
    S_EMITCHK,
    S_ERD,
    S_ELOAD,
    S_REPORT
  } state_t;

  state_t   state, state_next;
  status_t  rep_code, rep_code_next;
  ser_sel_t rep_sel, rep_sel_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    rep_code_next = rep_code;
    rep_sel_next  = rep_sel;
    cmd           = '0;
    cmd.rep_code  = rep_code;
    cmd.ser_sel   = rep_sel;
    unique case (state)
      S_IDLE: begin
        if (in_valid && final_item) begin
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        priority if (stat.overflowed) begin
          rep_code_next = ST_CAPACITY;
          rep_sel_next  = SEL_ZERO;
          state_next    = S_REPORT;
        end else if (stat.count_zero) begin
          rep_code_next = ST_NONE_LOADED;
          rep_sel_next  = SEL_ZERO;
          state_next    = S_REPORT;
        end else if (stat.too_many) begin
          rep_code_next = ST_TOO_MANY;
          rep_sel_next  = SEL_MAX;
          state_next    = S_REPORT;
        end else begin
          cmd.calc_lo = 1'b1;
          cmd.pos_clr = 1'b1;
          state_next  = S_RDPOS;
        end
      end
      S_RDPOS: begin
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.latch_cur = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat.oob) begin
          rep_code_next = ST_OUT_OF_BOUNDS;
          rep_sel_next  = SEL_CUR;
          state_next    = S_REPORT;
        end else if (stat.at_home) begin
          if (stat.last_pos) begin
            state_next = S_EMITCHK;
          end else begin
            cmd.pos_inc = 1'b1;
            state_next  = S_RDPOS;
          end
        end else begin
          cmd.rd_tgt = 1'b1;
          state_next = S_TGT;
        end
      end
      S_TGT: begin
        if (stat.dup) begin
          rep_code_next = ST_DUPLICATE;
          rep_sel_next  = SEL_CUR;
          state_next    = S_REPORT;
        end else begin
          cmd.wr_tgt = 1'b1;
          state_next = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd.wr_pos = 1'b1;
        state_next = S_CHECK;
      end
      S_EMITCHK: begin
        if (stat.none_emit) begin
          rep_code_next = ST_NONE_EMITTED;
          rep_sel_next  = SEL_FROM;
          state_next    = S_REPORT;
        end else begin
          cmd.emit_start = 1'b1;
          state_next     = S_ERD;
        end
      end
      S_ERD: begin
        if (stat.out_free) begin
          cmd.rd_emit = 1'b1;
          state_next  = S_ELOAD;
        end
      end
      S_ELOAD: begin
        cmd.load_entry = 1'b1;
        if (stat.last_emit) begin
          cmd.clear_load = 1'b1;
          state_next     = S_IDLE;
        end else begin
          state_next = S_ERD;
        end
      end
      S_REPORT: begin
        if (stat.out_free) begin
          cmd.report     = 1'b1;
          cmd.clear_load = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rep_code <= ST_ENTRY;
      rep_sel  <= SEL_ZERO;
    end else begin
      state    <= state_next;
      rep_code <= rep_code_next;
      rep_sel  <= rep_sel_next;
    end
  end

endmodule

/* src/sste_datapath.sv */
// ----------------------------------------------------------------------------
// sste_datapath
// Entry store, configuration registers, placement arithmetic and the
// output register of the sort and emit unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_slot_sort_and_tail_emit_unit_defines.svh"

module sste_datapath
  import sste_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [SER_W-1:0]     entry_serial,
  input  logic [TAG_W-1:0]     entry_tag,
  input  logic                 has_entry,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SER_W-1:0]     out_serial,
  output logic [TAG_W-1:0]     out_tag,
  output logic [STATUS_W-1:0]  status,
  output logic                 last_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SER_W-1:0]     cfg_data,
  input  sste_cmd_t            cmd,
  output sste_stat_t           stat
);

  logic [SER_W-1:0] newest_ser;
  logic [SER_W-1:0] held_ser;
  cnt_t             entry_count;
  logic             overflowed;
  idx_t             pos;
  idx_t             emit_idx;
  entry_t           cur;
  entry_t           tgt;
  logic [SER_W:0]   lo;

  logic             in_fire;
  logic             full;
  logic [SER_W+1:0] diff;
  idx_t             target;
  logic [SER_W:0]   max_p1;
  logic [SER_W-1:0] span;
  logic [SER_W:0]   count_w;
  logic [SER_W-1:0] count_s;
  cnt_t             emit_first;
  logic             ram_we;
  idx_t             ram_waddr;
  idx_t             ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [SER_W-1:0] rep_serial;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid & in_ready;
  assign full      = (entry_count >= CNT_W'(DEPTH));

  assign count_w    = {{(SER_W + 1 - CNT_W){1'b0}}, entry_count};
  assign count_s    = count_w[SER_W-1:0];
  assign max_p1     = {1'b0, newest_ser} + {{SER_W{1'b0}}, 1'b1};
  assign diff       = {2'b00, cur.ser} - {1'b0, lo};
  assign target     = diff[IDX_W-1:0];
  assign span       = newest_ser - held_ser;
  assign emit_first = entry_count - span[CNT_W-1:0];

  assign stat.overflowed = overflowed;
  assign stat.count_zero = (entry_count == '0);
  assign stat.too_many   = (max_p1 < count_w);
  assign stat.oob        = diff[SER_W+1] | (diff[SER_W:0] >= count_w);
  assign stat.at_home    = (target == pos);
  assign stat.dup        = (ram_rdata.ser == cur.ser);
  assign stat.last_pos   = (({1'b0, pos} + CNT_W'(1)) == entry_count);
  assign stat.none_emit  = (held_ser >= newest_ser) | (span > count_s);
  assign stat.last_emit  = (({1'b0, emit_idx} + CNT_W'(1)) == entry_count);
  assign stat.out_free   = ~out_valid | out_ready;

  always_comb begin
    ram_we    = cmd.wr_tgt | cmd.wr_pos | (in_fire & has_entry & ~full);
    ram_waddr = entry_count[IDX_W-1:0];
    ram_wdata = '{ser: entry_serial, tag: entry_tag};
    priority if (cmd.wr_tgt) begin
      ram_waddr = target;
      ram_wdata = cur;
    end else if (cmd.wr_pos) begin
      ram_waddr = pos;
      ram_wdata = tgt;
    end
  end

  always_comb begin
    priority if (cmd.rd_tgt) begin
      ram_raddr = target;
    end else if (cmd.rd_emit) begin
      ram_raddr = emit_idx;
    end else begin
      ram_raddr = pos;
    end
  end

  always_comb begin
    unique case (cmd.ser_sel)
      SEL_ZERO: rep_serial = '0;
      SEL_MAX:  rep_serial = newest_ser;
      SEL_CUR:  rep_serial = cur.ser;
      SEL_FROM: rep_serial = held_ser;
      default:  rep_serial = '0;
    endcase
  end

  sste_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_ser  <= '0;
      held_ser    <= '0;
      entry_count <= '0;
      overflowed  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NEWEST) begin
          newest_ser <= cfg_data;
        end
        if (cfg_index == REG_HELD) begin
          held_ser <= cfg_data;
        end
      end
      if (cmd.clear_load) begin
        entry_count <= '0;
        overflowed  <= 1'b0;
      end else if (in_fire && has_entry) begin
        if (full) begin
          overflowed <= 1'b1;
        end else begin
          entry_count <= entry_count + CNT_W'(1);
        end
      end
      if (cmd.load_entry || cmd.report) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_lo) begin
      lo <= max_p1 - count_w;
    end
    if (cmd.pos_clr) begin
      pos <= '0;
    end else if (cmd.pos_inc) begin
      pos <= pos + IDX_W'(1);
    end
    if (cmd.latch_cur) begin
      cur <= ram_rdata;
    end else if (cmd.wr_pos) begin
      cur <= tgt;
    end
    if (cmd.wr_tgt) begin
      tgt <= ram_rdata;
    end
    if (cmd.emit_start) begin
      emit_idx <= emit_first[IDX_W-1:0];
    end else if (cmd.load_entry) begin
      emit_idx <= emit_idx + IDX_W'(1);
    end
    if (cmd.load_entry) begin
      out_serial  <= ram_rdata.ser;
      out_tag     <= ram_rdata.tag;
      status      <= ST_ENTRY;
      last_result <= stat.last_emit;
    end else if (cmd.report) begin
      out_serial  <= rep_serial;
      out_tag     <= '0;
      status      <= cmd.rep_code;
      last_result <= 1'b1;
    end
  end

  `SSTE_ASSERT_NOW(a_count_bound, 1'b1, entry_count <= CNT_W'(DEPTH))
  `SSTE_ASSERT_NOW(a_overflow_full, overflowed, entry_count == CNT_W'(DEPTH))
  `SSTE_ASSERT_NOW(a_out_not_lost, cmd.load_entry || cmd.report, !out_valid || out_ready)
  `SSTE_ASSERT_NOW(a_swap_moves, cmd.wr_tgt, target != pos)
  `SSTE_ASSERT_NEXT(a_swap_pairs, cmd.wr_tgt, cmd.wr_pos)

endmodule

/* src/serial_slot_sort_and_tail_emit_unit.sv */
// ----------------------------------------------------------------------------
// serial_slot_sort_and_tail_emit_unit
// Loads serial/tag entries, sorts them in place by serial and emits the tail
// of the sequence above a given serial, or one status result.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid/in_ready    entry_serial, entry_tag, has_entry, final_item
//  output   out_valid/out_ready  out_serial, out_tag, status, last_result
//  config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Each request that does not close a load is accepted whenever the sequencer is idle.
//  A closing request runs a setup check, then the placement sort, which visits
//  each stored entry and swaps misplaced ones, then emits the tail one entry
//  at a time; the single port store serialises these steps.
//  Reset clears the entry count, the overflow flag, the config registers and
//  out_valid; the store is not cleared. A stalled output holds the sequencer;
//  the input is refused from closing until the run's last result is loaded.
`timescale 1ns / 1ps

module serial_slot_sort_and_tail_emit_unit
  import sste_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SER_W-1:0]     entry_serial,
  input  logic [TAG_W-1:0]     entry_tag,
  input  logic                 has_entry,
  input  logic                 final_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SER_W-1:0]     out_serial,
  output logic [TAG_W-1:0]     out_tag,
  output logic [STATUS_W-1:0]  status,
  output logic                 last_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SER_W-1:0]     cfg_data
);

  sste_cmd_t  cmd;
  sste_stat_t stat;

  sste_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .final_item (final_item),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sste_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .entry_serial (entry_serial),
    .entry_tag    (entry_tag),
    .has_entry    (has_entry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_serial   (out_serial),
    .out_tag      (out_tag),
    .status       (status),
    .last_result  (last_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
